FILE: rtl/core/i2c_master_byte_controller_unit_macros.svh
// Assertion macros shared by the I2C master byte controller RTL.
// Depends on nothing; each user supplies clk and rst_n in scope.
`ifndef I2C_MASTER_BYTE_CONTROLLER_UNIT_MACROS_SVH
`define I2C_MASTER_BYTE_CONTROLLER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define I2CM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define I2CM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/i2cm_pkg.sv
// Package for the I2C master byte controller: item types, codes, constants.
// Used by i2cm_front, i2cm_back and the top level.
package i2cm_pkg;

  localparam int QueueDepth = 4;

  localparam logic [7:0] QuarterTicksRst = 8'd3;
  localparam logic [9:0] AckWaitRst      = 10'd100;

  typedef enum logic [1:0] {
    ReqTick  = 2'd0,
    ReqBegin = 2'd1,
    ReqData  = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    EvNone  = 2'd0,
    EvByte  = 2'd1,
    EvStop  = 2'd2
  } event_t;

  typedef enum logic [0:0] {
    CfgQuarterTicks = 1'b0,
    CfgAckWait      = 1'b1
  } cfg_idx_t;

  // Item class as decided by the front end
  typedef enum logic [1:0] {
    CmdTick  = 2'd0,
    CmdBegin = 2'd1,
    CmdData  = 2'd2,
    CmdBad   = 2'd3
  } cmd_kind_t;

  typedef enum logic [8:0] {
    PhIdle    = 9'b000000001,
    PhStart   = 9'b000000010,
    PhTxBit   = 9'b000000100,
    PhAckBit  = 9'b000001000,
    PhAckWait = 9'b000010000,
    PhRxBit   = 9'b000100000,
    PhTxAck   = 9'b001000000,
    PhStop    = 9'b010000000,
    PhHold    = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       sda_in;
    logic [6:0] slave_addr;
    logic       read_not_write;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_pull_low;
    logic [1:0] event_code;
    logic [7:0] read_data;
    logic       acked;
    logic [7:0] byte_count;
    logic       busy_res;
    logic       cmd_rejected;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic       sda;
    logic [6:0] addr;
    logic       rnw;
    logic [7:0] data;
    logic       last;
  } cmd_t;

endpackage

FILE: rtl/core/i2cm_front.sv
// Front end: accepts input items, classifies them and queues them.
// Depends on i2cm_pkg and the assertion macro header.
`include "i2c_master_byte_controller_unit_macros.svh"

module i2cm_front #(
  parameter int Depth = i2cm_pkg::QueueDepth
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  i2cm_pkg::in_item_t in_item,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output i2cm_pkg::cmd_t     cmd
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  i2cm_pkg::cmd_t   queue_r [Depth];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  i2cm_pkg::cmd_t   cls;
  logic             push, pop;

  always_comb begin
    cls.sda  = in_item.sda_in;
    cls.addr = in_item.slave_addr;
    cls.rnw  = in_item.read_not_write;
    cls.data = in_item.data_byte;
    cls.last = in_item.last_byte;
    case (in_item.req_type)
      i2cm_pkg::ReqTick:  cls.kind = i2cm_pkg::CmdTick;
      i2cm_pkg::ReqBegin: cls.kind = i2cm_pkg::CmdBegin;
      i2cm_pkg::ReqData:  cls.kind = i2cm_pkg::CmdData;
      default:            cls.kind = i2cm_pkg::CmdBad;
    endcase
  end

  assign in_ready  = (cnt_r != CntW'(Depth));
  assign push      = in_valid && in_ready;
  assign cmd_valid = (cnt_r != '0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = queue_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CntW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= cls;
    end
  end

  `I2CM_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CntW'(Depth), "queue count over depth")
  `I2CM_ASSERT_NEXT(a_cnt_inc, push && !pop, cnt_r == $past(cnt_r) + CntW'(1), "push lost")
  `I2CM_ASSERT_NEXT(a_cnt_dec, pop && !push, cnt_r == $past(cnt_r) - CntW'(1), "pop lost")

endmodule

FILE: rtl/core/i2cm_back.sv
// Back end: bit sequencer that executes queued items and registers results.
// Depends on i2cm_pkg and the assertion macro header.
`include "i2c_master_byte_controller_unit_macros.svh"

module i2cm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  i2cm_pkg::cmd_t      cmd,
  input  logic [7:0]          quarter_ticks,
  input  logic [9:0]          ack_wait_ticks,
  output logic                out_valid,
  input  logic                out_ready,
  output i2cm_pkg::out_item_t out_item
);

  i2cm_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] qcnt_r, qcnt_nxt;
  logic [1:0] qidx_r, qidx_nxt;
  logic [3:0] bitcnt_r, bitcnt_nxt;
  logic [7:0] shreg_r, shreg_nxt;
  logic [9:0] awcnt_r, awcnt_nxt;
  logic [7:0] xfer_r, xfer_nxt;
  logic       rmode_r, rmode_nxt;
  logic       final_r, final_nxt;
  logic       scl_r, scl_nxt;
  logic       sdal_r, sdal_nxt;
  logic       addrb_r, addrb_nxt;
  logic       acked_r, acked_nxt;

  logic                out_valid_r;
  i2cm_pkg::out_item_t out_data_r;

  logic [7:0] len, qcnt_inc, xfer_sat;
  logic [9:0] wait_len, aw_inc;
  logic [3:0] bit_inc;
  logic [1:0] ev;
  logic [7:0] rd;
  logic       rej, pop;

  assign len      = (quarter_ticks == 8'd0) ? 8'd1 : quarter_ticks;
  assign wait_len = (ack_wait_ticks == 10'd0) ? 10'd1 : ack_wait_ticks;
  assign qcnt_inc = qcnt_r + 8'd1;
  assign aw_inc   = awcnt_r + 10'd1;
  assign bit_inc  = bitcnt_r + 4'd1;
  assign xfer_sat = (xfer_r == 8'hff) ? xfer_r : xfer_r + 8'd1;

  assign cmd_ready = !out_valid_r || out_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    phase_nxt  = phase_r;
    qcnt_nxt   = qcnt_r;
    qidx_nxt   = qidx_r;
    bitcnt_nxt = bitcnt_r;
    shreg_nxt  = shreg_r;
    awcnt_nxt  = awcnt_r;
    xfer_nxt   = xfer_r;
    rmode_nxt  = rmode_r;
    final_nxt  = final_r;
    scl_nxt    = scl_r;
    sdal_nxt   = sdal_r;
    addrb_nxt  = addrb_r;
    acked_nxt  = acked_r;
    ev         = i2cm_pkg::EvNone;
    rd         = 8'd0;
    rej        = 1'b0;
    case (cmd.kind)
      i2cm_pkg::CmdTick: begin
        if (phase_r != i2cm_pkg::PhIdle && phase_r != i2cm_pkg::PhHold) begin
          // pin drive for the current phase and quarter
          case (phase_r)
            i2cm_pkg::PhStart: begin
              scl_nxt  = (qidx_r < 2'd2);
              sdal_nxt = (qidx_r >= 2'd1);
            end
            i2cm_pkg::PhTxBit: begin
              scl_nxt  = (qidx_r == 2'd1) || (qidx_r == 2'd2);
              sdal_nxt = !shreg_r[~bitcnt_r[2:0]];
            end
            i2cm_pkg::PhTxAck: begin
              scl_nxt  = (qidx_r == 2'd1) || (qidx_r == 2'd2);
              sdal_nxt = !final_r;
            end
            i2cm_pkg::PhAckBit, i2cm_pkg::PhRxBit: begin
              scl_nxt  = (qidx_r == 2'd1) || (qidx_r == 2'd2);
              sdal_nxt = 1'b0;
            end
            i2cm_pkg::PhAckWait: begin
              scl_nxt  = 1'b1;
              sdal_nxt = 1'b0;
            end
            i2cm_pkg::PhStop: begin
              scl_nxt  = (qidx_r >= 2'd1);
              sdal_nxt = (qidx_r < 2'd2);
            end
            default: begin
            end
          endcase

          if (phase_r == i2cm_pkg::PhAckWait) begin
            awcnt_nxt = aw_inc;
            acked_nxt = acked_r || !cmd.sda;
            if (acked_nxt || aw_inc >= wait_len) begin
              phase_nxt = i2cm_pkg::PhAckBit;
              qidx_nxt  = 2'd2;
              qcnt_nxt  = 8'd0;
            end
          end else begin
            qcnt_nxt = qcnt_inc;
            if (qcnt_inc >= len) begin
              qcnt_nxt = 8'd0;
              // end of one quarter
              case (phase_r)
                i2cm_pkg::PhStart: begin
                  if (qidx_r < 2'd2) begin
                    qidx_nxt = qidx_r + 2'd1;
                  end else begin
                    phase_nxt  = i2cm_pkg::PhTxBit;
                    qidx_nxt   = 2'd0;
                    bitcnt_nxt = 4'd0;
                  end
                end
                i2cm_pkg::PhTxBit, i2cm_pkg::PhRxBit: begin
                  if (phase_r == i2cm_pkg::PhRxBit && qidx_r == 2'd1) begin
                    shreg_nxt = {shreg_r[6:0], cmd.sda};
                  end
                  if (qidx_r != 2'd3) begin
                    qidx_nxt = qidx_r + 2'd1;
                  end else begin
                    qidx_nxt   = 2'd0;
                    bitcnt_nxt = bit_inc;
                    if (bit_inc >= 4'd8) begin
                      bitcnt_nxt = 4'd0;
                      if (phase_r == i2cm_pkg::PhTxBit) begin
                        phase_nxt = i2cm_pkg::PhAckBit;
                        awcnt_nxt = 10'd0;
                      end else begin
                        phase_nxt = i2cm_pkg::PhTxAck;
                      end
                    end
                  end
                end
                i2cm_pkg::PhAckBit: begin
                  if (qidx_r == 2'd1) begin
                    phase_nxt = i2cm_pkg::PhAckWait;
                    awcnt_nxt = 10'd0;
                  end else if (qidx_r != 2'd3) begin
                    qidx_nxt = qidx_r + 2'd1;
                  end else begin
                    qidx_nxt = 2'd0;
                    if (!acked_r) begin
                      phase_nxt = i2cm_pkg::PhStop;
                    end else if (addrb_r) begin
                      addrb_nxt = 1'b0;
                      phase_nxt = i2cm_pkg::PhHold;
                      ev        = i2cm_pkg::EvByte;
                    end else begin
                      xfer_nxt  = xfer_sat;
                      ev        = i2cm_pkg::EvByte;
                      phase_nxt = final_r ? i2cm_pkg::PhStop : i2cm_pkg::PhHold;
                    end
                  end
                end
                i2cm_pkg::PhTxAck: begin
                  if (qidx_r != 2'd3) begin
                    qidx_nxt = qidx_r + 2'd1;
                  end else begin
                    qidx_nxt  = 2'd0;
                    xfer_nxt  = xfer_sat;
                    ev        = i2cm_pkg::EvByte;
                    rd        = shreg_r;
                    phase_nxt = final_r ? i2cm_pkg::PhStop : i2cm_pkg::PhHold;
                  end
                end
                i2cm_pkg::PhStop: begin
                  if (qidx_r < 2'd2) begin
                    qidx_nxt = qidx_r + 2'd1;
                  end else begin
                    qidx_nxt  = 2'd0;
                    phase_nxt = i2cm_pkg::PhIdle;
                    scl_nxt   = 1'b1;
                    sdal_nxt  = 1'b0;
                    ev        = i2cm_pkg::EvStop;
                  end
                end
                default: begin
                  phase_nxt = i2cm_pkg::PhIdle;
                  qidx_nxt  = 2'd0;
                end
              endcase
            end
          end
        end
      end
      i2cm_pkg::CmdBegin: begin
        if (phase_r == i2cm_pkg::PhIdle) begin
          rmode_nxt  = cmd.rnw;
          shreg_nxt  = {cmd.addr, cmd.rnw};
          xfer_nxt   = 8'd0;
          acked_nxt  = 1'b0;
          final_nxt  = 1'b0;
          addrb_nxt  = 1'b1;
          bitcnt_nxt = 4'd0;
          qidx_nxt   = 2'd0;
          qcnt_nxt   = 8'd0;
          phase_nxt  = i2cm_pkg::PhStart;
        end else begin
          rej = 1'b1;
        end
      end
      i2cm_pkg::CmdData: begin
        if (phase_r == i2cm_pkg::PhHold) begin
          final_nxt  = cmd.last;
          bitcnt_nxt = 4'd0;
          qidx_nxt   = 2'd0;
          qcnt_nxt   = 8'd0;
          if (rmode_r) begin
            shreg_nxt = 8'd0;
            phase_nxt = i2cm_pkg::PhRxBit;
          end else begin
            shreg_nxt = cmd.data;
            acked_nxt = 1'b0;
            phase_nxt = i2cm_pkg::PhTxBit;
          end
        end else begin
          rej = 1'b1;
        end
      end
      default: begin
        rej = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= i2cm_pkg::PhIdle;
      qcnt_r      <= 8'd0;
      qidx_r      <= 2'd0;
      bitcnt_r    <= 4'd0;
      shreg_r     <= 8'd0;
      awcnt_r     <= 10'd0;
      xfer_r      <= 8'd0;
      rmode_r     <= 1'b0;
      final_r     <= 1'b0;
      scl_r       <= 1'b1;
      sdal_r      <= 1'b0;
      addrb_r     <= 1'b0;
      acked_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        phase_r  <= phase_nxt;
        qcnt_r   <= qcnt_nxt;
        qidx_r   <= qidx_nxt;
        bitcnt_r <= bitcnt_nxt;
        shreg_r  <= shreg_nxt;
        awcnt_r  <= awcnt_nxt;
        xfer_r   <= xfer_nxt;
        rmode_r  <= rmode_nxt;
        final_r  <= final_nxt;
        scl_r    <= scl_nxt;
        sdal_r   <= sdal_nxt;
        addrb_r  <= addrb_nxt;
        acked_r  <= acked_nxt;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r.scl_level    <= scl_nxt;
      out_data_r.sda_pull_low <= sdal_nxt;
      out_data_r.event_code   <= ev;
      out_data_r.read_data    <= rd;
      out_data_r.acked        <= acked_nxt;
      out_data_r.byte_count   <= xfer_nxt;
      out_data_r.busy_res     <= (phase_nxt != i2cm_pkg::PhIdle) &&
                                 (phase_nxt != i2cm_pkg::PhHold);
      out_data_r.cmd_rejected <= rej;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_data_r;

  `I2CM_ASSERT_NEXT(a_rej_keeps_phase, pop && (cmd.kind == i2cm_pkg::CmdBad), phase_r == $past(phase_r), "bad item moved phase")
  `I2CM_ASSERT_NOW(a_stop_released, out_valid_r && (out_data_r.event_code == i2cm_pkg::EvStop), !out_data_r.busy_res && out_data_r.scl_level && !out_data_r.sda_pull_low, "STOP end not released")
  `I2CM_ASSERT_NEXT(a_stall_holds, out_valid_r && !out_ready, $stable(phase_r) && $stable(xfer_r), "state moved under stall")

endmodule

FILE: rtl/core/i2c_master_byte_controller_unit.sv
// Top level of the I2C master byte controller: config registers, front end, back end.
// Depends on i2cm_pkg, i2cm_front and i2cm_back.
//
// Open-drain I2C master driven one item at a time. Each input item is a
// tick (one base time unit, carrying the sampled SDA level), a begin command
// (START, seven-bit address and direction bit, then ACK wait) or a data
// command (one byte written MSB first or read and answered ACK/NAK). Every
// item yields exactly one result item with the SCL/SDA drive levels, an
// event code, received data, ACK status, byte count and busy/reject flags.
// Commands take no time: their pin levels repeat those of the item before.
// Throughput is one item per clock cycle while the result side does not stall;
// the whole bit sequencer updates for each item in the back end. An item passes
// through the input queue and then the result register; a result-side stall holds it.
// A four-entry queue (QDepth) separates the input handshake from the
// sequencer. While a result waits in the result register the sequencer
// holds, and the queue keeps taking items until it is full; in_ready then
// stays low until the result side moves again. Registers: index 0
// quarter_ticks (ticks per SCL quarter, 0 acts as 1, reset 3), index 1
// ack_wait_ticks (ACK window in ticks, 0 acts as 1, reset 100). Write them
// only while the block is idle. Not handled: pin setup and clock stretching.

module i2c_master_byte_controller_unit #(
  parameter int QDepth = i2cm_pkg::QueueDepth
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  i2cm_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output i2cm_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_idx,
  input  logic [9:0]          cfg_wdata
);

  logic [7:0] quarter_ticks_r;
  logic [9:0] ack_wait_r;

  logic           cmd_valid;
  logic           cmd_ready;
  i2cm_pkg::cmd_t cmd;

  // config registers; plain write, no read-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quarter_ticks_r <= i2cm_pkg::QuarterTicksRst;
      ack_wait_r      <= i2cm_pkg::AckWaitRst;
    end else if (cfg_we) begin
      case (cfg_idx)
        i2cm_pkg::CfgQuarterTicks: quarter_ticks_r <= cfg_wdata[7:0];
        i2cm_pkg::CfgAckWait:      ack_wait_r      <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // classify and queue
  i2cm_front #(
    .Depth (QDepth)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // bit sequencer and result register
  i2cm_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd_valid),
    .cmd_ready      (cmd_ready),
    .cmd            (cmd),
    .quarter_ticks  (quarter_ticks_r),
    .ack_wait_ticks (ack_wait_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_item       (out_item)
  );

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the I2C master byte controller (i2c_master_byte_controller_unit).
// Needs i2cm_pkg and the controller RTL only; predicts every result item in-line and
// compares it field by field against what the block returns.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // req_type value with no meaning: the block must refuse it
  localparam logic [1:0] ReqUnused = 2'd3;

  // How the modeled slave answers in the ACK window
  localparam int AckNever  = 0;  // SDA stays high, NAK
  localparam int AckAtOnce = 1;  // SDA low on the first sample
  localparam int AckLate   = 2;  // SDA low on a randomly chosen sample
  localparam int AckMixed  = 3;  // per byte: mostly late ACK, sometimes NAK

  localparam int HoldOffCycles = 120;   // long receiver stall to fill the block
  localparam int WatchdogLimit = 3000;  // cycles with no item moving on either side
  localparam int MaxShown      = 40;    // error lines printed before going quiet

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  i2cm_pkg::in_item_t  in_item;
  logic                out_valid;
  logic                out_ready;
  i2cm_pkg::out_item_t out_item;
  logic                cfg_we;
  logic [0:0]          cfg_idx;
  logic [9:0]          cfg_wdata;

  always #4 clk = ~clk;

  i2c_master_byte_controller_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Bus sequencer predictor. Mirrors the controller one item at a time; it is
  // advanced when an input item is accepted, so the stimulus can look at it to
  // decide what the slave puts on SDA next.
  // ---------------------------------------------------------------------------
  logic [7:0] qtr_len_cfg;   // quarter_ticks copy
  logic [9:0] ack_win_cfg;   // ack_wait_ticks copy

  i2cm_pkg::phase_t ph_q;
  logic [7:0] qtr_cnt;
  logic [1:0] qtr_idx;
  logic [3:0] bit_idx;
  logic [7:0] shifter;
  logic [9:0] ack_cnt;
  logic [7:0] xfer_cnt;
  logic       rd_mode;
  logic       last_pend;
  logic       addr_pending;  // byte in flight is the address byte
  logic       ack_seen;
  logic       scl_drv;
  logic       sda_drv;       // 1 pulls SDA low
  i2cm_pkg::event_t step_ev;
  logic [7:0] step_rd;

  i2cm_pkg::out_item_t expected_pins[$];  // predicted result items, oldest first

  int error_count, items_sent, results_seen, refused_cmds, transfers_done;
  int stall_cycles;
  logic gaps_on, noise_on, hold_off_req;
  i2cm_pkg::out_item_t want;

  function automatic void sequencer_reset();
    qtr_len_cfg = i2cm_pkg::QuarterTicksRst;
    ack_win_cfg = i2cm_pkg::AckWaitRst;
    ph_q = i2cm_pkg::PhIdle;
    qtr_cnt = '0;
    qtr_idx = '0;
    bit_idx = '0;
    shifter = '0;
    ack_cnt = '0;
    xfer_cnt = '0;
    rd_mode = 1'b0;
    last_pend = 1'b0;
    addr_pending = 1'b0;
    ack_seen = 1'b0;
    scl_drv = 1'b1;
    sda_drv = 1'b0;
  endfunction

  // Pin levels for the current quarter of the running phase
  function automatic void pins_update();
    logic [2:0] bsel;
    bsel = 3'd7 - bit_idx[2:0];
    case (ph_q)
      i2cm_pkg::PhStart: begin
        scl_drv = (qtr_idx < 2'd2);
        sda_drv = (qtr_idx >= 2'd1);
      end
      i2cm_pkg::PhTxBit: begin
        scl_drv = (qtr_idx == 2'd1 || qtr_idx == 2'd2);
        sda_drv = ~shifter[bsel];
      end
      i2cm_pkg::PhTxAck: begin
        scl_drv = (qtr_idx == 2'd1 || qtr_idx == 2'd2);
        sda_drv = ~last_pend;
      end
      i2cm_pkg::PhAckBit, i2cm_pkg::PhRxBit: begin
        scl_drv = (qtr_idx == 2'd1 || qtr_idx == 2'd2);
        sda_drv = 1'b0;
      end
      i2cm_pkg::PhAckWait: begin
        scl_drv = 1'b1;
        sda_drv = 1'b0;
      end
      i2cm_pkg::PhStop: begin
        scl_drv = (qtr_idx >= 2'd1);
        sda_drv = (qtr_idx < 2'd2);
      end
      default: ;
    endcase
  endfunction

  function automatic void enter_stop();
    ph_q = i2cm_pkg::PhStop;
    qtr_idx = 2'd0;
  endfunction

  function automatic void bump_count();
    if (xfer_cnt != 8'hff) xfer_cnt = xfer_cnt + 8'd1;
  endfunction

  // End of the ACK bit of an address or write byte
  function automatic i2cm_pkg::event_t ack_outcome();
    if (!ack_seen) begin
      enter_stop();
      return i2cm_pkg::EvNone;
    end
    if (addr_pending) begin
      addr_pending = 1'b0;
      ph_q = i2cm_pkg::PhHold;
      return i2cm_pkg::EvByte;
    end
    bump_count();
    if (last_pend) enter_stop();
    else ph_q = i2cm_pkg::PhHold;
    return i2cm_pkg::EvByte;
  endfunction

  function automatic void quarter_done(logic sda);
    case (ph_q)
      i2cm_pkg::PhStart: begin
        if (qtr_idx < 2'd2) qtr_idx = qtr_idx + 2'd1;
        else begin
          ph_q = i2cm_pkg::PhTxBit;
          qtr_idx = 2'd0;
          bit_idx = 4'd0;
        end
      end
      i2cm_pkg::PhTxBit, i2cm_pkg::PhRxBit: begin
        // read bits are taken at the end of the first SCL-high quarter
        if (ph_q == i2cm_pkg::PhRxBit && qtr_idx == 2'd1) shifter = {shifter[6:0], sda};
        if (qtr_idx < 2'd3) qtr_idx = qtr_idx + 2'd1;
        else begin
          qtr_idx = 2'd0;
          bit_idx = bit_idx + 4'd1;
          if (bit_idx >= 4'd8) begin
            bit_idx = 4'd0;
            if (ph_q == i2cm_pkg::PhTxBit) begin
              ph_q = i2cm_pkg::PhAckBit;
              ack_cnt = '0;
            end else begin
              ph_q = i2cm_pkg::PhTxAck;
            end
          end
        end
      end
      i2cm_pkg::PhAckBit: begin
        if (qtr_idx == 2'd1) begin
          ph_q = i2cm_pkg::PhAckWait;
          ack_cnt = '0;
        end else if (qtr_idx < 2'd3) begin
          qtr_idx = qtr_idx + 2'd1;
        end else begin
          qtr_idx = 2'd0;
          step_ev = ack_outcome();
        end
      end
      i2cm_pkg::PhTxAck: begin
        if (qtr_idx < 2'd3) qtr_idx = qtr_idx + 2'd1;
        else begin
          qtr_idx = 2'd0;
          bump_count();
          step_ev = i2cm_pkg::EvByte;
          step_rd = shifter;
          if (last_pend) enter_stop();
          else ph_q = i2cm_pkg::PhHold;
        end
      end
      i2cm_pkg::PhStop: begin
        if (qtr_idx < 2'd2) qtr_idx = qtr_idx + 2'd1;
        else begin
          qtr_idx = 2'd0;
          ph_q = i2cm_pkg::PhIdle;
          scl_drv = 1'b1;
          sda_drv = 1'b0;
          step_ev = i2cm_pkg::EvStop;
        end
      end
      default: begin
        ph_q = i2cm_pkg::PhIdle;
        qtr_idx = 2'd0;
      end
    endcase
  endfunction

  function automatic void tick_step(logic sda);
    logic [9:0] win;
    logic [7:0] len;
    if (ph_q == i2cm_pkg::PhIdle || ph_q == i2cm_pkg::PhHold) return;
    pins_update();
    if (ph_q == i2cm_pkg::PhAckWait) begin
      win = (ack_win_cfg == 10'd0) ? 10'd1 : ack_win_cfg;
      ack_cnt = ack_cnt + 10'd1;
      if (!sda) ack_seen = 1'b1;
      if (ack_seen || ack_cnt >= win) begin
        ph_q = i2cm_pkg::PhAckBit;
        qtr_idx = 2'd2;
        qtr_cnt = '0;
      end
      return;
    end
    len = (qtr_len_cfg == 8'd0) ? 8'd1 : qtr_len_cfg;
    qtr_cnt = qtr_cnt + 8'd1;
    if (qtr_cnt >= len) begin
      qtr_cnt = '0;
      quarter_done(sda);
    end
  endfunction

  // Advance the sequencer by one accepted item and build its result item
  function automatic i2cm_pkg::out_item_t predict_pins(i2cm_pkg::in_item_t it);
    i2cm_pkg::out_item_t r;
    logic                rej;
    step_ev = i2cm_pkg::EvNone;
    step_rd = '0;
    rej = 1'b0;
    case (it.req_type)
      i2cm_pkg::ReqTick: tick_step(it.sda_in);
      i2cm_pkg::ReqBegin: begin
        if (ph_q == i2cm_pkg::PhIdle) begin
          rd_mode = it.read_not_write;
          shifter = {it.slave_addr, it.read_not_write};
          xfer_cnt = '0;
          ack_seen = 1'b0;
          last_pend = 1'b0;
          addr_pending = 1'b1;
          bit_idx = '0;
          qtr_idx = '0;
          qtr_cnt = '0;
          ph_q = i2cm_pkg::PhStart;
        end else begin
          rej = 1'b1;
        end
      end
      i2cm_pkg::ReqData: begin
        if (ph_q == i2cm_pkg::PhHold) begin
          last_pend = it.last_byte;
          bit_idx = '0;
          qtr_idx = '0;
          qtr_cnt = '0;
          if (rd_mode) begin
            shifter = '0;
            ph_q = i2cm_pkg::PhRxBit;
          end else begin
            shifter = it.data_byte;
            ack_seen = 1'b0;
            ph_q = i2cm_pkg::PhTxBit;
          end
        end else begin
          rej = 1'b1;
        end
      end
      default: rej = 1'b1;
    endcase
    r.scl_level    = scl_drv;
    r.sda_pull_low = sda_drv;
    r.event_code   = step_ev;
    r.read_data    = step_rd;
    r.acked        = ack_seen;
    r.byte_count   = xfer_cnt;
    r.busy_res     = (ph_q != i2cm_pkg::PhIdle && ph_q != i2cm_pkg::PhHold);
    r.cmd_rejected = rej;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Error reporting and result checking
  // ---------------------------------------------------------------------------
  task automatic flag_error(string msg);
    error_count++;
    if (error_count <= MaxShown) $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic cmp_field(string name, logic [7:0] got, logic [7:0] want_v);
    if (got !== want_v)
      flag_error($sformatf("result %0d: %s is %0h, predicted %0h",
                           results_seen, name, got, want_v));
  endtask

  // Every accepted result item is matched to the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_pins.size() == 0) begin
        flag_error($sformatf("result %0d arrived with no item pending", results_seen));
      end else begin
        want = expected_pins.pop_front();
        cmp_field("scl_level",    8'(out_item.scl_level),    8'(want.scl_level));
        cmp_field("sda_pull_low", 8'(out_item.sda_pull_low), 8'(want.sda_pull_low));
        cmp_field("event_code",   8'(out_item.event_code),   8'(want.event_code));
        cmp_field("read_data",    out_item.read_data,        want.read_data);
        cmp_field("acked",        8'(out_item.acked),        8'(want.acked));
        cmp_field("byte_count",   out_item.byte_count,       want.byte_count);
        cmp_field("busy_res",     8'(out_item.busy_res),     8'(want.busy_res));
        cmp_field("cmd_rejected", 8'(out_item.cmd_rejected), 8'(want.cmd_rejected));
      end
    end
  end

  // Watchdog: no item moving on either channel for too long ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WatchdogLimit) begin
      $display("TIMEOUT: no item moved for %0d cycles", stall_cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request so the
  // input queue and result register fill and in_ready drops.
  always begin
    @(negedge clk);
    if (hold_off_req) begin
      out_ready <= 1'b0;
      repeat (HoldOffCycles) @(negedge clk);
      hold_off_req = 1'b0;
      out_ready <= 1'b1;
    end else if (gaps_on && rst_n && $urandom_range(0, 11) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. All of them are entered and left at a falling edge.
  // ---------------------------------------------------------------------------

  // Offer one item; valid stays up afterwards unless the next call idles first
  task automatic offer_item(i2cm_pkg::in_item_t it);
    i2cm_pkg::out_item_t p;
    if (gaps_on && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    p = predict_pins(it);
    if (p.cmd_rejected) refused_cmds++;
    expected_pins.push_back(p);
    items_sent++;
    @(negedge clk);
  endtask

  // Random contents in every field, then the request type forced
  function automatic i2cm_pkg::in_item_t any_item(logic [1:0] req);
    logic [$bits(i2cm_pkg::in_item_t)-1:0] raw;
    i2cm_pkg::in_item_t it;
    raw = $bits(i2cm_pkg::in_item_t)'($urandom);
    it = raw;
    it.req_type = req;
    return it;
  endfunction

  task automatic send_tick(logic sda);
    i2cm_pkg::in_item_t it;
    it = any_item(i2cm_pkg::ReqTick);
    it.sda_in = sda;
    offer_item(it);
  endtask

  // What the slave puts on SDA for the next tick
  function automatic logic slave_sda(int ack_mode);
    if (ph_q != i2cm_pkg::PhAckWait) return 1'($urandom_range(0, 1));
    case (ack_mode)
      AckAtOnce: return 1'b0;
      AckLate:   return ($urandom_range(0, 2) == 0) ? 1'b0 : 1'b1;
      default:   return 1'b1;
    endcase
  endfunction

  function automatic int pick_ack(int mode);
    if (mode != AckMixed) return mode;
    return ($urandom_range(0, 7) == 0) ? AckNever : AckLate;
  endfunction

  // Tick until the sequencer is idle or waiting for a data command
  task automatic run_bits(int ack_mode);
    i2cm_pkg::in_item_t it;
    while (ph_q != i2cm_pkg::PhIdle && ph_q != i2cm_pkg::PhHold) begin
      if (noise_on && $urandom_range(0, 60) == 0) begin
        // any command while a sequence runs must be refused
        it = any_item(2'($urandom_range(1, 3)));
        offer_item(it);
      end else begin
        send_tick(slave_sda(ack_mode));
      end
    end
  endtask

  // One bus transaction: START + address, then nbytes data bytes, last one flagged
  task automatic i2c_transfer(logic rnw, logic [6:0] addr, int nbytes, int addr_ack,
                              logic [7:0] first_data, int data_ack);
    i2cm_pkg::in_item_t it;
    it = any_item(i2cm_pkg::ReqBegin);
    it.slave_addr = addr;
    it.read_not_write = rnw;
    offer_item(it);
    run_bits(pick_ack(addr_ack));
    for (int i = 0; i < nbytes && ph_q == i2cm_pkg::PhHold; i++) begin
      if (noise_on && $urandom_range(0, 3) == 0) begin
        // waiting for data: ticks change nothing, begin and junk are refused
        repeat ($urandom_range(1, 3)) send_tick(1'($urandom_range(0, 1)));
        it = any_item($urandom_range(0, 1) ? i2cm_pkg::ReqBegin : ReqUnused);
        offer_item(it);
      end
      it = any_item(i2cm_pkg::ReqData);
      it.last_byte = (i == nbytes - 1);
      if (i == 0) it.data_byte = first_data;
      else if (i == 1) it.data_byte = ~first_data;
      offer_item(it);
      run_bits(pick_ack(data_ack));
    end
    transfers_done++;
  endtask

  // A random item of any kind, then whatever it takes to get back to idle
  task automatic noise_item();
    i2cm_pkg::in_item_t it;
    it = any_item(2'($urandom_range(0, 3)));
    offer_item(it);
    run_bits(AckMixed);
    while (ph_q == i2cm_pkg::PhHold) begin
      it = any_item(i2cm_pkg::ReqData);
      it.last_byte = 1'b1;
      offer_item(it);
      run_bits(AckMixed);
    end
  endtask

  // Stop offering and wait for every pending result, then let the pipe settle
  task automatic drain();
    int n;
    in_valid <= 1'b0;
    n = 0;
    while (expected_pins.size() != 0 && n < 20000) begin
      @(negedge clk);
      n++;
    end
    repeat (6) @(negedge clk);
  endtask

  // Both registers, written back to back while the block is idle
  task automatic set_timing(logic [7:0] qt, logic [9:0] aw);
    drain();
    cfg_we    <= 1'b1;
    cfg_idx   <= i2cm_pkg::CfgQuarterTicks;
    cfg_wdata <= {2'b00, qt};
    @(negedge clk);
    cfg_idx   <= i2cm_pkg::CfgAckWait;
    cfg_wdata <= aw;
    @(negedge clk);
    cfg_we    <= 1'b0;
    qtr_len_cfg = qt;
    ack_win_cfg = aw;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Command acceptance rules at the reset timing values
  task automatic test_command_rules();
    i2cm_pkg::in_item_t it;
    send_tick(1'b0);                     // idle ticks hold the pins
    send_tick(1'b1);
    it = any_item(i2cm_pkg::ReqData);    // data while idle
    offer_item(it);
    it = any_item(ReqUnused);            // undefined request type
    offer_item(it);
    it = any_item(i2cm_pkg::ReqBegin);
    it.slave_addr = 7'h7f;
    it.read_not_write = 1'b1;
    offer_item(it);
    it = any_item(i2cm_pkg::ReqBegin);   // begin while the address goes out
    offer_item(it);
    it = any_item(i2cm_pkg::ReqData);    // data while the address goes out
    offer_item(it);
    run_bits(AckAtOnce);
    send_tick(1'b1);                     // waiting for data: nothing moves
    it = any_item(i2cm_pkg::ReqBegin);   // begin while waiting for data
    offer_item(it);
    it = any_item(ReqUnused);
    offer_item(it);
    it = any_item(i2cm_pkg::ReqData);    // single read byte, NAKed, then STOP
    it.last_byte = 1'b1;
    offer_item(it);
    run_bits(AckAtOnce);
  endtask

  // Write and read with field extremes, address NAK
  task automatic test_write_read();
    i2cm_pkg::in_item_t it;
    set_timing(8'd0, 10'd1);
    i2c_transfer(1'b0, 7'h00, 1, AckAtOnce, 8'hff, AckAtOnce);
    i2c_transfer(1'b0, 7'h2a, 1, AckNever, 8'h00, AckAtOnce);
    it = any_item(i2cm_pkg::ReqData);    // data after a failed address
    offer_item(it);
    i2c_transfer(1'b1, 7'h7f, 2, AckAtOnce, 8'h00, AckAtOnce);
  endtask

  // Zero ACK window with a data NAK, then the widest ACK window
  task automatic test_timing_extremes();
    set_timing(8'd0, 10'd0);
    i2c_transfer(1'b0, 7'h41, 2, AckAtOnce, 8'h00, AckNever);
    set_timing(8'd0, 10'd1023);
    i2c_transfer(1'b0, 7'h13, 1, AckLate, 8'h3c, AckLate);
  endtask

  // Random traffic with random timing and the long receiver hold-off
  task automatic test_random_traffic();
    int first_item;
    int r;
    noise_on = 1'b1;
    set_timing(8'($urandom_range(0, 1)), 10'($urandom_range(0, 12)));
    hold_off_req = 1'b1;
    first_item = items_sent;
    while (items_sent - first_item < 60) begin
      r = $urandom_range(0, 99);
      if (r < 12) noise_item();
      else i2c_transfer(1'($urandom_range(0, 1)), 7'($urandom), $urandom_range(1, 2),
                        (r < 20) ? AckNever : AckLate, 8'($urandom), AckMixed);
    end
    noise_on = 1'b0;
  endtask

  // Last stretch with both sides always ready
  task automatic test_clean_tail();
    gaps_on = 1'b0;
    set_timing(8'd1, 10'd8);
    i2c_transfer(1'b0, 7'($urandom), 1, AckAtOnce, 8'($urandom), AckLate);
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_item      = '0;
    out_ready    = 1'b1;
    cfg_we       = 1'b0;
    cfg_idx      = i2cm_pkg::CfgQuarterTicks;
    cfg_wdata    = '0;
    gaps_on      = 1'b1;
    noise_on     = 1'b0;
    hold_off_req = 1'b0;
    error_count  = 0;
    items_sent   = 0;
    results_seen = 0;
    refused_cmds = 0;
    transfers_done = 0;
    stall_cycles = 0;
    sequencer_reset();

    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_command_rules();
    test_write_read();
    test_timing_extremes();
    test_random_traffic();
    test_clean_tail();

    drain();
    if (expected_pins.size() != 0)
      flag_error($sformatf("%0d predicted results never arrived", expected_pins.size()));

    $display("Run covered %0d items and %0d result items, %0d bus transfers, %0d refused commands,",
             items_sent, results_seen, transfers_done, refused_cmds);
    $display("reset and short quarters, ACK windows 0 to 1023, ACK/NAK paths and back-pressure.");
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/i2cm_pkg.sv
rtl/core/i2cm_front.sv
rtl/core/i2cm_back.sv
rtl/core/i2c_master_byte_controller_unit.sv
tb/sv/tb.sv
